@@ rtl/polyphonic_oscillator_mixer_core_assert.svh @@
// Assertion macros shared by the oscillator mixer RTL.
`ifndef POLYPHONIC_OSCILLATOR_MIXER_CORE_ASSERT_SVH
`define POLYPHONIC_OSCILLATOR_MIXER_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define POM_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define POM_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

@@ rtl/pom_pkg.sv @@
// Package with types and constants of the oscillator mixer.
package pom_pkg;
    localparam logic [2:0] CFG_WAVEFORM = 3'd0;
    localparam logic [2:0] CFG_GAIN_SINE = 3'd1;
    localparam logic [2:0] CFG_GAIN_SQUARE = 3'd2;
    localparam logic [2:0] CFG_GAIN_TRIANGLE = 3'd3;
    localparam logic [1:0] MODE_TICK = 2'd0;
    localparam logic [1:0] MODE_NOTE_ON = 2'd1;
    localparam logic [1:0] MODE_NOTE_OFF = 2'd2;
    localparam logic [1:0] MODE_NOP = 2'd3;
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_DUPLICATE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;
    localparam logic [2:0] WF_SINE = 3'd0;
    localparam logic [2:0] WF_SQUARE = 3'd1;
    localparam logic [2:0] WF_TRIANGLE = 3'd2;
    localparam logic [2:0] WF_SQ_SINE = 3'd3;
    localparam logic [2:0] WF_SQ_TRI = 3'd4;
    localparam logic [2:0] WF_2SINE_TRI = 3'd5;
    localparam logic [2:0] WF_ALL = 3'd6;
    localparam logic [31:0] Q30_HALF_PI = 32'd1686629713;
    localparam logic [31:0] Q30_POLY_B = 32'd688904866;
    localparam logic [31:0] Q30_POLY_C = 32'd76016977;
    localparam logic [31:0] Q30_SQUARE = 32'd429496730;
    typedef enum logic [4:0] {
        S_IDLE, S_SEARCH, S_SHIFT, S_PH_A, S_PH_B,
        S_V0, S_V1, S_V2, S_V3, S_V4, S_V5, S_V6, S_V7, S_V8, S_V9, S_V10, S_V11,
        S_DIV, S_OUT
    } state_t;
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [6:0]  divisor;
    } div_req_t;
    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;
endpackage

@@ rtl/pom_if.sv @@
// Valid/ready channel interfaces of the oscillator mixer.
interface pom_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] phase_step;
    modport source (output valid, mode, phase_step, input ready);
    modport sink (input valid, mode, phase_step, output ready);
endinterface

interface pom_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               sample_valid;
    logic [4:0]         voice_count;
    logic [1:0]         event_status;
    modport source (output valid, sample, sample_valid, voice_count, event_status,
        input ready);
    modport sink (input valid, sample, sample_valid, voice_count, event_status,
        output ready);
endinterface

interface pom_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/pom_divider.sv @@
// Restoring divider that takes one quotient bit per cycle.
module pom_divider
    import pom_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);
    logic [63:0] quot_reg;
    logic [6:0]  rem_reg;
    logic [6:0]  dsr_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [7:0]  trial;

    assign trial = {rem_reg, quot_reg[63]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quot_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_reg <= 7'(trial - {1'b0, dsr_reg});
                quot_reg <= {quot_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[6:0];
                quot_reg <= {quot_reg[62:0], 1'b0};
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quotient = quot_reg;
endmodule

@@ rtl/polyphonic_oscillator_mixer_core.sv @@
// Top level of the polyphonic oscillator mixer.
// One word in gives one word out. A note on or off scans the voice table one slot a
// cycle; a word of the unused mode goes straight to the output stage. A tick runs
// each voice through the single shared 32x32 multiplier, then starts the bit-serial
// divider, waits for it and takes the result; with no voices it does not start it.
// The result waits in an output register, so the next word is accepted and worked
// on meanwhile; it finishes only once that register is free.
module polyphonic_oscillator_mixer_core
    import pom_pkg::*;
#(
    parameter int MAX_VOICES = 16,
    parameter int PHASE_BITS = 32
)
(
    input logic clk,
    input logic rst_n,
    pom_in_if.sink   in_ch,
    pom_out_if.source out_ch,
    pom_cfg_if.sink  cfg_ch
);
`include "polyphonic_oscillator_mixer_core_assert.svh"
    localparam int IW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int CW = $clog2(MAX_VOICES + 1);

    logic [31:0] step_mem [MAX_VOICES];
    logic [31:0] phase_mem [MAX_VOICES];

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic [31:0]   counter_reg;
    logic [2:0]    wave_reg;
    logic [14:0]   gs_reg, gq_reg, gt_reg;
    logic [1:0]    mode_reg;
    logic [31:0]   key_reg;
    logic [31:0]   rd_reg;
    logic [31:0]   u_reg;
    logic [31:0]   m_reg, m2_reg, r_reg;
    logic [31:0]   smag_reg, tmag_reg;
    logic          neg_reg;
    logic signed [63:0] acc_reg, sum_reg;
    logic [31:0]   mul_a, mul_b;
    logic [63:0]   prod;
    logic [63:0]   prod_reg;
    logic          ovalid_reg;
    logic signed [15:0] osample_reg;
    logic          osv_reg;
    logic [4:0]    ocount_reg;
    logic [1:0]    ostat_reg;
    logic signed [15:0] smp_reg;
    logic          sv_reg;
    logic [1:0]    stat_reg;
    logic          out_free;
    div_req_t      dreq;
    div_rsp_t      drsp;
    logic          found;
    logic [IW-1:0] idx;
    logic [IW-1:0] idx1;
    logic [IW-1:0] rd_addr;
    logic [31:0]   term;
    logic signed [63:0] sterm;
    logic [63:0]   mag;
    logic [48:0]   rq;

    assign idx = idx_reg[IW-1:0];
    assign idx1 = IW'(idx_reg + CW'(1));
    assign rd_addr = (state_reg == S_IDLE) ? '0 :
        ((state_reg == S_SEARCH || state_reg == S_SHIFT) ? idx1 : idx);
    assign found = (rd_reg == key_reg);
    assign prod = mul_a * mul_b;
    assign term = prod[47:16];
    assign out_free = !ovalid_reg || out_ch.ready;

    pom_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign in_ch.ready = (state_reg == S_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.sample = osample_reg;
    assign out_ch.sample_valid = osv_reg;
    assign out_ch.voice_count = ocount_reg;
    assign out_ch.event_status = ostat_reg;

    always_comb
    begin
        mul_a = m_reg;
        mul_b = m_reg;
        unique case (state_reg)
            S_PH_B: begin mul_a = rd_reg; mul_b = counter_reg; end
            S_V2: begin mul_a = m_reg; mul_b = m_reg; end
            S_V3: begin mul_a = m2_reg; mul_b = Q30_POLY_C; end
            S_V4: begin mul_a = m2_reg; mul_b = r_reg; end
            S_V5: begin mul_a = m_reg; mul_b = r_reg; end
            S_V6: begin mul_a = m_reg; mul_b = Q30_HALF_PI; end
            S_V7: begin mul_a = smag_reg; mul_b = {17'd0, gs_reg}; end
            S_V8: begin mul_a = tmag_reg; mul_b = {17'd0, gt_reg}; end
            S_V9: begin mul_a = Q30_SQUARE; mul_b = {17'd0, gq_reg}; end
            default: begin mul_a = m_reg; mul_b = m_reg; end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_ch.valid && in_ch.ready)
                    state_next = (in_ch.mode == MODE_TICK) ? S_PH_A :
                        ((in_ch.mode == MODE_NOTE_ON || in_ch.mode == MODE_NOTE_OFF) ?
                        S_SEARCH : S_OUT);
            S_SEARCH:
                if (idx_reg >= count_reg) state_next = S_OUT;
                else if (found) state_next = (mode_reg == MODE_NOTE_OFF) ? S_SHIFT : S_OUT;
            S_SHIFT: if (CW'(idx_reg + CW'(1)) >= count_reg) state_next = S_OUT;
            S_PH_A: state_next = (idx_reg >= count_reg) ? S_DIV : S_PH_B;
            S_PH_B: state_next = S_V0;
            S_V0: state_next = S_V1;
            S_V1: state_next = S_V2;
            S_V2: state_next = S_V3;
            S_V3: state_next = S_V4;
            S_V4: state_next = S_V5;
            S_V5: state_next = S_V6;
            S_V6: state_next = S_V7;
            S_V7: state_next = S_V8;
            S_V8: state_next = S_V9;
            S_V9: state_next = S_V10;
            S_V10: state_next = S_V11;
            S_V11: state_next = S_PH_A;
            S_DIV: if (drsp.done || count_reg == '0) state_next = S_OUT;
            S_OUT: if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        dreq.start = (state_reg == S_PH_A) && (idx_reg >= count_reg) && (count_reg != '0);
        mag = sum_reg[63] ? 64'(-sum_reg) : 64'(sum_reg);
        dreq.dividend = mag;
        dreq.divisor = 7'(count_reg);
        rq = 49'((drsp.quotient + 64'd16384) >> 15);
        sterm = neg_reg ? -$signed({32'd0, term}) : $signed({32'd0, term});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            counter_reg <= '0;
            wave_reg <= WF_SINE;
            gs_reg <= 15'd16384;
            gq_reg <= 15'd16384;
            gt_reg <= 15'd16384;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                unique case (cfg_ch.index)
                    CFG_WAVEFORM: wave_reg <= cfg_ch.data[2:0];
                    CFG_GAIN_SINE: gs_reg <= cfg_ch.data[14:0];
                    CFG_GAIN_SQUARE: gq_reg <= cfg_ch.data[14:0];
                    CFG_GAIN_TRIANGLE: gt_reg <= cfg_ch.data[14:0];
                    default: ;
                endcase
            end
            if (state_reg == S_OUT && out_free) ovalid_reg <= 1'b1;
            else if (out_ch.valid && out_ch.ready) ovalid_reg <= 1'b0;
            if (state_reg == S_OUT && out_free && mode_reg == MODE_TICK)
                counter_reg <= counter_reg + 32'd1;
            if (state_reg == S_SEARCH && idx_reg >= count_reg && mode_reg == MODE_NOTE_ON
                && count_reg < CW'(MAX_VOICES))
                count_reg <= count_reg + CW'(1);
            if (state_reg == S_SHIFT && CW'(idx_reg + CW'(1)) >= count_reg)
                count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        if (state_reg == S_IDLE || state_reg == S_SEARCH || state_reg == S_SHIFT
            || state_reg == S_PH_A)
            rd_reg <= step_mem[rd_addr];
        unique case (state_reg)
            S_IDLE:
            begin
                mode_reg <= in_ch.mode;
                key_reg <= in_ch.phase_step;
                idx_reg <= '0;
                sum_reg <= '0;
                stat_reg <= ST_DONE;
                smp_reg <= '0;
                sv_reg <= 1'b0;
            end
            S_SEARCH:
            begin
                if (idx_reg >= count_reg)
                begin
                    if (mode_reg == MODE_NOTE_OFF) stat_reg <= ST_NOT_FOUND;
                    else if (count_reg >= CW'(MAX_VOICES)) stat_reg <= ST_FULL;
                    else
                    begin
                        step_mem[idx] <= key_reg;
                        phase_mem[idx] <= '0;
                    end
                end
                else if (found)
                begin
                    if (mode_reg == MODE_NOTE_ON) stat_reg <= ST_DUPLICATE;
                end
                else idx_reg <= idx_reg + CW'(1);
            end
            S_SHIFT:
            begin
                if (CW'(idx_reg + CW'(1)) < count_reg)
                begin
                    step_mem[idx] <= step_mem[idx1];
                    phase_mem[idx] <= phase_mem[idx1];
                    idx_reg <= idx_reg + CW'(1);
                end
            end
            S_PH_A: ;
            S_PH_B: ;
            S_V0:
            begin
                u_reg <= prod_reg[31:0] << (32 - PHASE_BITS);
                phase_mem[idx] <= 32'(prod_reg[PHASE_BITS-1:0]);
                acc_reg <= '0;
                m_reg <= '0;
            end
            S_V1:
            begin
                if (u_reg < 32'h4000_0000) begin m_reg <= u_reg; neg_reg <= 1'b0; end
                else if (u_reg <= 32'h8000_0000)
                begin m_reg <= 32'h8000_0000 - u_reg; neg_reg <= 1'b0; end
                else if (u_reg < 32'hC000_0000)
                begin m_reg <= u_reg - 32'h8000_0000; neg_reg <= 1'b1; end
                else begin m_reg <= 32'(33'h1_0000_0000 - {1'b0, u_reg}); neg_reg <= 1'b1; end
            end
            S_V2: m2_reg <= prod[61:30];
            S_V3: r_reg <= Q30_POLY_B - prod[61:30];
            S_V4: r_reg <= Q30_HALF_PI - prod[61:30];
            S_V5: smag_reg <= prod[61:30];
            S_V6: tmag_reg <= prod[61:30];
            S_V7:
                if (wave_reg == WF_SINE || wave_reg == WF_SQ_SINE || wave_reg == WF_ALL)
                    acc_reg <= acc_reg + sterm;
                else if (wave_reg == WF_2SINE_TRI) acc_reg <= acc_reg + (sterm <<< 1);
            S_V8:
                if (wave_reg == WF_TRIANGLE || wave_reg == WF_SQ_TRI
                    || wave_reg == WF_2SINE_TRI || wave_reg == WF_ALL)
                    acc_reg <= acc_reg + sterm;
            S_V9:
            begin
                if (wave_reg == WF_SQUARE || wave_reg == WF_SQ_SINE
                    || wave_reg == WF_SQ_TRI || wave_reg == WF_ALL)
                begin
                    if (u_reg != 0 && u_reg < 32'h8000_0000)
                        acc_reg <= acc_reg + $signed({32'd0, term});
                    else acc_reg <= acc_reg - $signed({32'd0, term});
                end
            end
            S_V10: sum_reg <= sum_reg + acc_reg;
            S_V11: idx_reg <= idx_reg + CW'(1);
            S_DIV:
            begin
                sv_reg <= 1'b1;
                if (count_reg == '0) smp_reg <= '0;
                else if (sum_reg[63])
                    smp_reg <= (rq > 49'd32768) ? -16'sd32768 : 16'(-$signed(rq));
                else smp_reg <= (rq > 49'd32767) ? 16'sd32767 : 16'(rq);
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    ocount_reg <= 5'(count_reg);
                    ostat_reg <= stat_reg;
                    osample_reg <= smp_reg;
                    osv_reg <= sv_reg;
                end
            end
            default: ;
        endcase
    end

    `POM_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ch.ready, state_reg == S_IDLE)
    `POM_ASSERT_NEXT(a_out_after_done, clk, rst_n, state_reg == S_OUT && out_free, ovalid_reg)
    `POM_ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_reg <= CW'(MAX_VOICES))
    `POM_ASSERT_IMP(a_div_idle, clk, rst_n, state_reg == S_IDLE, !drsp.busy)
endmodule
